// ===== design/sgcr_pkg.sv =====
// Shared types, codes and helpers of the scaled glyph column renderer.
`default_nettype none

package sgcr_pkg;

  localparam logic [1:0] OP_LOAD_BITS = 2'd0;
  localparam logic [1:0] OP_LOAD_INFO = 2'd1;
  localparam logic [1:0] OP_DRAW      = 2'd2;

  localparam logic [1:0] CFG_POINT_SIZE  = 2'd0;
  localparam logic [1:0] CFG_CELL_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_CELL_HEIGHT = 2'd2;
  localparam logic [1:0] CFG_INK_COLOR   = 2'd3;

  localparam logic [6:0]  RESET_POINT_SIZE  = 7'd16;
  localparam logic [5:0]  RESET_CELL_WIDTH  = 6'd16;
  localparam logic [5:0]  RESET_CELL_HEIGHT = 6'd16;
  localparam logic [15:0] RESET_INK_COLOR   = 16'd0;

  localparam logic [5:0] CELL_MAX = 6'd32;

  typedef enum logic [1:0] {
    KIND_BITS,
    KIND_INFO,
    KIND_DRAW
  } sgcr_kind_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  char_code;
    logic [6:0]  byte_index;
    logic [7:0]  byte_value;
    logic [7:0]  advance_units;
    logic        present_flag;
    logic [11:0] origin_x;
    logic [11:0] origin_y;
    logic [5:0]  cell_column;
  } sgcr_in_t;

  typedef struct packed {
    logic        write_enable;
    logic [18:0] pixel_offset;
    logic [15:0] pixel_color;
    logic [13:0] char_advance;
    logic        last;
  } sgcr_out_t;

  typedef struct packed {
    logic [6:0]  point_size;
    logic [5:0]  font_cell_width;
    logic [5:0]  font_cell_height;
    logic [15:0] ink_color;
  } sgcr_cfg_t;

  typedef struct packed {
    sgcr_kind_e  kind;
    logic [7:0]  char_code;
    logic [6:0]  byte_index;
    logic [7:0]  byte_value;
    logic [7:0]  advance_units;
    logic        present_flag;
    logic        in_font;
    logic        col_ok;
    logic [6:0]  size;
    logic [5:0]  cw;
    logic [5:0]  qs;
    logic [6:0]  rs;
    logic [9:0]  pxch;
    logic [12:0] dy0;
    logic [18:0] dxh;
  } sgcr_entry_t;

  function automatic logic [5:0] sat_cell(input logic [5:0] v);
    logic [5:0] r;
    if (v == 6'd0) begin
      r = 6'd1;
    end else if (v > CELL_MAX) begin
      r = CELL_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/sgcr_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none

module sgcr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                          wdata_i,
  input  wire logic                                      re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/sgcr_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none

module sgcr_div #(
  parameter int unsigned NW = 12,
  parameter int unsigned DW = 7
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] dividend_i,
  input  wire logic [DW-1:0] divisor_i,
  output logic               done_o,
  output logic      [NW-1:0] quotient_o,
  output logic      [DW-1:0] remainder_o
);

  localparam int unsigned CNW = $clog2(NW);

  logic           busy_q, done_q;
  logic [CNW-1:0] cnt_q;
  logic [NW-1:0]  dq_q;
  logic [DW-1:0]  rem_q, dsr_q;
  logic [DW:0]    shifted, diff;
  logic           ge;

  always_comb begin
    shifted = {rem_q, dq_q[NW-1]};
    ge      = shifted >= {1'b0, dsr_q};
    diff    = shifted - {1'b0, dsr_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNW'(NW - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - CNW'(1);
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      dq_q  <= {dq_q[NW-2:0], ge};
      rem_q <= ge ? diff[DW-1:0] : shifted[DW-1:0];
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = dq_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

// ===== design/sgcr_fifo.sv =====
// Command queue between the front and back parts.
`default_nettype none

module sgcr_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire sgcr_pkg::sgcr_entry_t entry_i,
  input  wire logic                 pop_i,
  output sgcr_pkg::sgcr_entry_t     entry_o,
  output logic                      full_o,
  output logic                      empty_o
);

  import sgcr_pkg::*;

  localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  sgcr_entry_t     slots_q [DEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [CNTW-1:0] cnt_q;

  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (p == PW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PW'(1);
    end
    return r;
  endfunction

  assign full_o  = cnt_q == CNTW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign entry_o = slots_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= next_ptr(wr_q);
      end
      if (pop_i) begin
        rd_q <= next_ptr(rd_q);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + CNTW'(1);
        2'b01:   cnt_q <= cnt_q - CNTW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/sgcr_front.sv =====
// Front part: accepts transactions, drops unused ones, prepares draw commands.
`default_nettype none

module sgcr_front #(
  parameter int unsigned GLYPH_COUNT    = 128,
  parameter int unsigned GLYPH_BYTES    = 128,
  parameter int unsigned MAX_POINT_SIZE = 64,
  parameter int unsigned SCREEN_WIDTH   = 800,
  parameter int unsigned SCREEN_HEIGHT  = 480
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire sgcr_pkg::sgcr_in_t    in_data_i,
  input  wire sgcr_pkg::sgcr_cfg_t   cfg_i,
  input  wire logic                  full_i,
  output logic                       push_o,
  output sgcr_pkg::sgcr_entry_t      entry_o
);

  import sgcr_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_PX   = 2'd1;
  localparam logic [1:0] F_CH   = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  logic [1:0]  state_q, state_d;
  logic        acc, is_draw, code_ok, byte_ok;
  logic [6:0]  size_c;
  logic [5:0]  cw_c, ch_c;
  logic [12:0] dx_c;
  sgcr_entry_t load_entry, draw_entry;

  logic        div_start, div_done;
  logic [11:0] div_dvd, div_quo;
  logic [6:0]  div_dsr, div_rem;

  logic [7:0]  code_q;
  logic        in_font_q, col_ok_q;
  logic [6:0]  size_q, rs_q;
  logic [5:0]  cw_q, ch_q, qs_q;
  logic [12:0] dx_q, dy0_q;
  logic [18:0] dxh_q;
  logic [4:0]  px_q;
  logic [9:0]  pxch_q;

  always_comb begin
    if (cfg_i.point_size == 7'd0) begin
      size_c = 7'd1;
    end else if (32'(cfg_i.point_size) > MAX_POINT_SIZE) begin
      size_c = 7'(MAX_POINT_SIZE);
    end else begin
      size_c = cfg_i.point_size;
    end
    cw_c = sat_cell(cfg_i.font_cell_width);
    ch_c = sat_cell(cfg_i.font_cell_height);
    dx_c = 13'(in_data_i.origin_x) + 13'(in_data_i.cell_column);
  end

  assign in_stall_o = (state_q != F_IDLE) || full_i;
  assign acc        = in_valid_i && !in_stall_o;
  assign is_draw    = in_data_i.operation == OP_DRAW;
  assign code_ok    = 32'(in_data_i.char_code) < GLYPH_COUNT;
  assign byte_ok    = 32'(in_data_i.byte_index) < GLYPH_BYTES;

  always_comb begin
    load_entry               = '0;
    load_entry.kind          = (in_data_i.operation == OP_LOAD_BITS) ? KIND_BITS : KIND_INFO;
    load_entry.char_code     = in_data_i.char_code;
    load_entry.byte_index    = in_data_i.byte_index;
    load_entry.byte_value    = in_data_i.byte_value;
    load_entry.advance_units = in_data_i.advance_units;
    load_entry.present_flag  = in_data_i.present_flag;

    draw_entry           = '0;
    draw_entry.kind      = KIND_DRAW;
    draw_entry.char_code = code_q;
    draw_entry.in_font   = in_font_q;
    draw_entry.col_ok    = col_ok_q;
    draw_entry.size      = size_q;
    draw_entry.cw        = cw_q;
    draw_entry.qs        = qs_q;
    draw_entry.rs        = rs_q;
    draw_entry.pxch      = pxch_q;
    draw_entry.dy0       = dy0_q;
    draw_entry.dxh       = dxh_q;
  end

  always_comb begin
    push_o = 1'b0;
    if (state_q == F_PUSH) begin
      push_o = !full_i;
    end else if (acc) begin
      push_o = ((in_data_i.operation == OP_LOAD_BITS) && code_ok && byte_ok) ||
               ((in_data_i.operation == OP_LOAD_INFO) && code_ok);
    end
    entry_o = (state_q == F_PUSH) ? draw_entry : load_entry;
  end

  assign div_start = (acc && is_draw) || ((state_q == F_PX) && div_done);
  assign div_dvd   = (state_q == F_IDLE) ? (12'(in_data_i.cell_column) * 12'(cw_c))
                                         : 12'(ch_q);
  assign div_dsr   = (state_q == F_IDLE) ? size_c : size_q;

  sgcr_div #(
    .NW(12),
    .DW(7)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dvd),
    .divisor_i   (div_dsr),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: if (acc && is_draw) state_d = F_PX;
      F_PX:   if (div_done) state_d = F_CH;
      F_CH:   if (div_done) state_d = F_PUSH;
      F_PUSH: if (!full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && is_draw) begin
      code_q    <= in_data_i.char_code;
      in_font_q <= !in_data_i.char_code[7] && code_ok;
      col_ok_q  <= ({1'b0, in_data_i.cell_column} < size_c) && (32'(dx_c) < SCREEN_WIDTH);
      size_q    <= size_c;
      cw_q      <= cw_c;
      ch_q      <= ch_c;
      dx_q      <= dx_c;
      dy0_q     <= 13'(in_data_i.origin_y) + 13'(size_c);
    end
    if (state_q == F_PX) begin
      dxh_q <= 19'(32'(dx_q) * SCREEN_HEIGHT);
      if (div_done) begin
        px_q <= div_quo[4:0];
      end
    end
    if (state_q == F_CH) begin
      pxch_q <= 10'(11'(px_q) * 11'(ch_q));
      if (div_done) begin
        qs_q <= div_quo[5:0];
        rs_q <= div_rem;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/sgcr_back.sv =====
// Back part: applies font loads and walks the rows of a draw column.
`default_nettype none

module sgcr_back #(
  parameter int unsigned GLYPH_COUNT   = 128,
  parameter int unsigned GLYPH_BYTES   = 128,
  parameter int unsigned SCREEN_HEIGHT = 480
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  empty_i,
  input  wire sgcr_pkg::sgcr_entry_t entry_i,
  output logic                       pop_o,
  input  wire logic [15:0]           ink_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output sgcr_pkg::sgcr_out_t        out_data_o
);

  import sgcr_pkg::*;

  localparam int unsigned CIW        = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
  localparam int unsigned BITS_DEPTH = GLYPH_COUNT * GLYPH_BYTES;
  localparam int unsigned BAW        = (BITS_DEPTH > 1) ? $clog2(BITS_DEPTH) : 1;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_ADV  = 2'd1;
  localparam logic [1:0] B_DIV  = 2'd2;
  localparam logic [1:0] B_ROWS = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [GLYPH_COUNT-1:0] valid_q;
  sgcr_entry_t            e_q;
  logic                   drawable_q;
  logic [13:0]            adv_q;

  logic [CIW-1:0] head_idx, cur_idx;
  logic           bits_we, info_we, adv_re;
  logic [BAW-1:0] bits_waddr, bits_raddr;
  logic [7:0]     bits_rdata, adv_rdata;

  logic        div_start, div_done;
  logic [14:0] div_quo;
  logic [5:0]  div_rem;

  logic [5:0]  y_q, q_q;
  logic [6:0]  r_q;
  logic [12:0] dy_q;
  logic [18:0] off_q;

  logic        issue, row_last, in_bytes, wrap;
  logic [10:0] bit_off;
  logic [7:0]  byte_sel, r_sum;

  logic        s1_v_q, s1_we_q, s1_last_q, s1_move;
  logic [2:0]  s1_sel_q;
  logic [18:0] s1_off_q;
  logic [13:0] s1_adv_q;
  logic        out_v_q, out_take, hit;
  sgcr_out_t   out_q, result;

  assign pop_o      = (state_q == B_IDLE) && !empty_i;
  assign head_idx   = entry_i.char_code[CIW-1:0];
  assign cur_idx    = e_q.char_code[CIW-1:0];
  assign bits_we    = pop_o && (entry_i.kind == KIND_BITS);
  assign info_we    = pop_o && (entry_i.kind == KIND_INFO);
  assign adv_re     = pop_o && (entry_i.kind == KIND_DRAW);
  assign bits_waddr = BAW'(32'(head_idx) * GLYPH_BYTES + 32'(entry_i.byte_index));

  always_comb begin
    bit_off    = 11'(e_q.pxch) + 11'(q_q);
    byte_sel   = bit_off[10:3];
    in_bytes   = 32'(byte_sel) < GLYPH_BYTES;
    bits_raddr = BAW'(32'(cur_idx) * GLYPH_BYTES + 32'(byte_sel));
    row_last   = {1'b0, y_q} == (e_q.size - 7'd1);
    r_sum      = 8'(r_q) + 8'(e_q.rs);
    wrap       = r_sum >= 8'(e_q.size);
  end

  assign out_take = out_v_q && !out_stall_i;
  assign s1_move  = s1_v_q && (!out_v_q || out_take);
  assign issue    = (state_q == B_ROWS) && (!s1_v_q || s1_move);

  sgcr_ram #(
    .WIDTH(8),
    .DEPTH(BITS_DEPTH)
  ) u_bits_ram (
    .clk_i   (clk_i),
    .we_i    (bits_we),
    .waddr_i (bits_waddr),
    .wdata_i (entry_i.byte_value),
    .re_i    (issue),
    .raddr_i (bits_raddr),
    .rdata_o (bits_rdata)
  );

  sgcr_ram #(
    .WIDTH(8),
    .DEPTH(GLYPH_COUNT)
  ) u_adv_ram (
    .clk_i   (clk_i),
    .we_i    (info_we),
    .waddr_i (head_idx),
    .wdata_i (entry_i.advance_units),
    .re_i    (adv_re),
    .raddr_i (head_idx),
    .rdata_o (adv_rdata)
  );

  assign div_start = state_q == B_ADV;

  sgcr_div #(
    .NW(15),
    .DW(6)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (15'(adv_rdata) * 15'(e_q.size)),
    .divisor_i   (e_q.cw),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: if (adv_re) state_d = B_ADV;
      B_ADV:  state_d = B_DIV;
      B_DIV:  if (div_done) state_d = B_ROWS;
      B_ROWS: if (issue && row_last) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    hit                 = s1_we_q && bits_rdata[s1_sel_q];
    result.write_enable = hit;
    result.pixel_offset = hit ? s1_off_q : 19'd0;
    result.pixel_color  = hit ? ink_i : 16'd0;
    result.char_advance = s1_adv_q;
    result.last         = s1_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      valid_q <= '0;
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (info_we) begin
        valid_q[head_idx] <= entry_i.present_flag;
      end
      if (issue) begin
        s1_v_q <= 1'b1;
      end else if (s1_move) begin
        s1_v_q <= 1'b0;
      end
      if (s1_move) begin
        out_v_q <= 1'b1;
      end else if (out_take) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_re) begin
      e_q        <= entry_i;
      drawable_q <= entry_i.in_font && entry_i.col_ok && valid_q[head_idx];
    end
    if ((state_q == B_DIV) && div_done) begin
      adv_q <= e_q.in_font ? div_quo[13:0] : 14'd0;
      y_q   <= '0;
      q_q   <= '0;
      r_q   <= '0;
      dy_q  <= e_q.dy0;
      off_q <= 19'(e_q.dy0) + e_q.dxh;
    end else if (issue) begin
      y_q   <= y_q + 6'd1;
      q_q   <= q_q + e_q.qs + (wrap ? 6'd1 : 6'd0);
      r_q   <= wrap ? 7'(r_sum - 8'(e_q.size)) : 7'(r_sum);
      dy_q  <= dy_q - 13'd1;
      off_q <= off_q - 19'd1;
    end
    if (issue) begin
      s1_we_q   <= drawable_q && in_bytes && (32'(dy_q) < SCREEN_HEIGHT);
      s1_sel_q  <= bit_off[2:0];
      s1_off_q  <= off_q;
      s1_last_q <= row_last;
      s1_adv_q  <= adv_q;
    end
    if (s1_move) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== design/scaled_glyph_column_renderer.sv =====
// Top level of the scaled glyph column renderer.
// Holds a 1-bit font and renders one column of a nearest-neighbor scaled glyph cell per draw
// transaction, giving one result per row with the framebuffer offset, ink color, scaled
// advance and a last flag. A draw column occupies the back while it reads the glyph advance,
// runs the radix-2 advance divider, then gives one row per cycle out of the bitmap RAM read
// port while the output is not stalled. The front does its own two 12-bit divisions per draw,
// so with small point sizes the front sets the pace. A queue of QUEUE_DEPTH commands lets the
// front prepare the next draw while the back streams rows. The user must write configuration
// only while the block is idle; the block itself does not enforce this.
`default_nettype none

module scaled_glyph_column_renderer #(
  parameter int unsigned GLYPH_COUNT    = 128,
  parameter int unsigned GLYPH_BYTES    = 128,
  parameter int unsigned MAX_POINT_SIZE = 64,
  parameter int unsigned SCREEN_WIDTH   = 800,
  parameter int unsigned SCREEN_HEIGHT  = 480,
  parameter int unsigned QUEUE_DEPTH    = 2
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire sgcr_pkg::sgcr_in_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output sgcr_pkg::sgcr_out_t      out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_idx_i,
  input  wire logic [15:0]         cfg_data_i
);

  import sgcr_pkg::*;

  sgcr_cfg_t   cfg_q;
  sgcr_entry_t push_entry, head_entry;
  logic        push, pop, full, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.point_size       <= RESET_POINT_SIZE;
      cfg_q.font_cell_width  <= RESET_CELL_WIDTH;
      cfg_q.font_cell_height <= RESET_CELL_HEIGHT;
      cfg_q.ink_color        <= RESET_INK_COLOR;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_POINT_SIZE:  cfg_q.point_size       <= cfg_data_i[6:0];
        CFG_CELL_WIDTH:  cfg_q.font_cell_width  <= cfg_data_i[5:0];
        CFG_CELL_HEIGHT: cfg_q.font_cell_height <= cfg_data_i[5:0];
        CFG_INK_COLOR:   cfg_q.ink_color        <= cfg_data_i;
        default:         cfg_q                  <= cfg_q;
      endcase
    end
  end

  sgcr_front #(
    .GLYPH_COUNT   (GLYPH_COUNT),
    .GLYPH_BYTES   (GLYPH_BYTES),
    .MAX_POINT_SIZE(MAX_POINT_SIZE),
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg_q),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  sgcr_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .full_o  (full),
    .empty_o (empty)
  );

  sgcr_back #(
    .GLYPH_COUNT  (GLYPH_COUNT),
    .GLYPH_BYTES  (GLYPH_BYTES),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .entry_i     (head_entry),
    .pop_o       (pop),
    .ink_i       (cfg_q.ink_color),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
